>>> src/gtpi_pkg.sv
// ----------------------------------------------------------------------------
// gtpi_pkg
// Shared types and constants of the grid trilinear particle interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package gtpi_pkg;

  localparam int GridSideDef  = 16;
  localparam int MaxFieldsDef = 3;
  localparam int CellWords    = 4096;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;

  localparam logic [23:0] LoClamp = 24'h008001;

  typedef enum logic [2:0] {
    REG_RANK        = 3'd0,
    REG_FILL_MODE   = 3'd1,
    REG_FIELD_COUNT = 3'd2,
    REG_GRID_DIMS   = 3'd3,
    REG_LEFT_EDGE_X = 3'd4,
    REG_LEFT_EDGE_Y = 3'd5,
    REG_LEFT_EDGE_Z = 3'd6,
    REG_INV_CELL    = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_INTERP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [1:0]         rank;
    logic               fill_mode;
    logic [1:0]         field_count;
    logic [23:0]        grid_dims;
    logic signed [31:0] left_edge_x;
    logic signed [31:0] left_edge_y;
    logic signed [31:0] left_edge_z;
    logic [31:0]        inv_cell_size;
  } cfg_t;

  // Work handed from the front to the back: either a store write or a
  // fully classified particle with its corner base and weights.
  typedef struct packed {
    logic               is_load;
    logic [1:0]         field_select;
    logic [11:0]        cell_address;
    logic signed [31:0] field_word;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [11:0]        base;
    logic [11:0]        nx;
    logic [11:0]        nxny;
    logic [16:0]        w0;
    logic [16:0]        w1;
    logic [16:0]        w2;
    logic [1:0]         rank;
    logic               fill_mode;
    logic [1:0]         nf;
    logic               batch_end;
  } job_t;

endpackage

`default_nettype wire

>>> src/grid_trilinear_particle_interp_core.sv
// ----------------------------------------------------------------------------
// grid_trilinear_particle_interp_core
// Cloud-in-cell interpolation of up to three grid fields at tracer positions.
// ----------------------------------------------------------------------------
// Flow: a particle passes F_MUL and F_CLAMP per used axis, then F_BASE1,
//   F_BASE2 and F_PUSH in the front (shared 32x32 multiplier); per field
//   the back issues 2^rank reads of the one-read-port store, captures the
//   last read word, does 1, 3 or 7 linear steps and emits one output;
//   positions one a cycle if not stalled; one item at a time in each half.
// Reset clears all control state and the registers to their defaults; the
//   field store is undefined until loaded and is not cleared.
`default_nettype none

module grid_trilinear_particle_interp_core #(
  parameter int GRID_SIDE  = gtpi_pkg::GridSideDef,
  parameter int MAX_FIELDS = gtpi_pkg::MaxFieldsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gtpi_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [gtpi_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            cmd_i,
  input  wire logic [1:0]                      field_select_i,
  input  wire logic [11:0]                     cell_address_i,
  input  wire logic signed [31:0]              field_word_i,
  input  wire logic signed [31:0]              pos_x_i,
  input  wire logic signed [31:0]              pos_y_i,
  input  wire logic signed [31:0]              pos_z_i,
  input  wire logic                            is_tracer_i,
  input  wire logic                            batch_end_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [31:0]                   value_o,
  output logic                                 kind_o,
  output logic [1:0]                           slot_o,
  output logic                                 last_of_particle_o,
  output logic                                 batch_done_o
);

  gtpi_pkg::cfg_t cfg_q;
  gtpi_pkg::job_t push_job, head_job;
  logic           push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rank          <= 2'd3;
      cfg_q.fill_mode     <= 1'b0;
      cfg_q.field_count   <= 2'd3;
      cfg_q.grid_dims     <= 24'h101010;
      cfg_q.left_edge_x   <= '0;
      cfg_q.left_edge_y   <= '0;
      cfg_q.left_edge_z   <= '0;
      cfg_q.inv_cell_size <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (gtpi_pkg::cfg_reg_e'(cfg_index_i))
        gtpi_pkg::REG_RANK:        cfg_q.rank          <= cfg_data_i[1:0];
        gtpi_pkg::REG_FILL_MODE:   cfg_q.fill_mode     <= cfg_data_i[0];
        gtpi_pkg::REG_FIELD_COUNT: cfg_q.field_count   <= cfg_data_i[1:0];
        gtpi_pkg::REG_GRID_DIMS:   cfg_q.grid_dims     <= cfg_data_i[23:0];
        gtpi_pkg::REG_LEFT_EDGE_X: cfg_q.left_edge_x   <= cfg_data_i;
        gtpi_pkg::REG_LEFT_EDGE_Y: cfg_q.left_edge_y   <= cfg_data_i;
        gtpi_pkg::REG_LEFT_EDGE_Z: cfg_q.left_edge_z   <= cfg_data_i;
        gtpi_pkg::REG_INV_CELL:    cfg_q.inv_cell_size <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gtpi_front #(
    .GridSide  (GRID_SIDE),
    .MaxFields (MAX_FIELDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .field_select_i (field_select_i),
    .cell_address_i (cell_address_i),
    .field_word_i   (field_word_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .is_tracer_i    (is_tracer_i),
    .batch_end_i    (batch_end_i),
    .push_o         (push),
    .job_o          (push_job),
    .full_i         (full)
  );

  gtpi_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (empty)
  );

  gtpi_back #(
    .MaxFields (MAX_FIELDS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (empty),
    .job_i              (head_job),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .value_o            (value_o),
    .kind_o             (kind_o),
    .slot_o             (slot_o),
    .last_of_particle_o (last_of_particle_o),
    .batch_done_o       (batch_done_o)
  );

endmodule

`default_nettype wire

>>> src/gtpi_ram.sv
// ----------------------------------------------------------------------------
// gtpi_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpi_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/gtpi_fifo.sv
// ----------------------------------------------------------------------------
// gtpi_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpi_fifo #(
  parameter int Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire gtpi_pkg::job_t  data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output gtpi_pkg::job_t       data_o,
  output logic                 empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  gtpi_pkg::job_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/gtpi_front.sv
// ----------------------------------------------------------------------------
// gtpi_front
// Accepts items, drops those without results, and turns a particle into its
// corner base and per-axis weights with one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpi_front #(
  parameter int GridSide  = gtpi_pkg::GridSideDef,
  parameter int MaxFields = gtpi_pkg::MaxFieldsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gtpi_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic [1:0]         field_select_i,
  input  wire logic [11:0]        cell_address_i,
  input  wire logic signed [31:0] field_word_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic               is_tracer_i,
  input  wire logic               batch_end_i,
  output logic                    push_o,
  output gtpi_pkg::job_t          job_o,
  input  wire logic               full_i
);

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_MUL   = 6'b000010,
    F_CLAMP = 6'b000100,
    F_BASE1 = 6'b001000,
    F_BASE2 = 6'b010000,
    F_PUSH  = 6'b100000
  } front_state_e;

  function automatic logic [7:0] dim_sat(input logic [7:0] n);
    logic [7:0] r;
    r = n;
    if (r < 8'd2) r = 8'd2;
    if (r > 8'(GridSide)) r = 8'(GridSide);
    return r;
  endfunction

  front_state_e       state_q, state_d;
  logic [1:0]         ax_q, ax_d;
  logic signed [31:0] pos_q [3];
  logic               batch_q;
  logic [7:0]         cell_q [3];
  logic [16:0]        w_q [3];
  logic [63:0]        prod_q;
  logic               neg_q, hi_q;
  logic [11:0]        t_q;
  gtpi_pkg::job_t     job_q;

  logic [7:0]         nx, ny, nz, nsel;
  logic [1:0]         nf, npos;
  logic [2:0]         total;
  logic               accept;
  logic signed [31:0] edge_sel;
  logic signed [32:0] diff;
  logic [64:0]        full_prod;
  logic [48:0]        u_full;
  logic [23:0]        hi_lim, u;
  logic [7:0]         cell_new;
  logic [24:0]        w_new;

  assign nx = dim_sat(cfg_i.grid_dims[7:0]);
  assign ny = dim_sat(cfg_i.grid_dims[15:8]);
  assign nz = dim_sat(cfg_i.grid_dims[23:16]);

  assign nf    = (int'(cfg_i.field_count) > MaxFields) ? 2'(MaxFields) : cfg_i.field_count;
  assign npos  = cfg_i.fill_mode ? cfg_i.rank : 2'd0;
  assign total = 3'(nf) + 3'(npos);

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign job_o      = job_q;

  always_comb begin
    unique case (ax_q)
      2'd1:    begin edge_sel = cfg_i.left_edge_y; nsel = ny; end
      2'd2:    begin edge_sel = cfg_i.left_edge_z; nsel = nz; end
      default: begin edge_sel = cfg_i.left_edge_x; nsel = nx; end
    endcase
  end

  assign diff = 33'(pos_q[ax_q]) - 33'(edge_sel);

  // Clamp in cell units, then split into lower cell and its weight.
  always_comb begin
    full_prod = {1'b0, prod_q} + (hi_q ? {1'b0, cfg_i.inv_cell_size, 32'h0} : 65'd0);
    u_full    = full_prod[64:16];
    hi_lim    = {nsel, 16'h0} - gtpi_pkg::LoClamp;
    if (neg_q || u_full < 49'(gtpi_pkg::LoClamp)) begin
      u = gtpi_pkg::LoClamp;
    end else if (u_full > 49'(hi_lim)) begin
      u = hi_lim;
    end else begin
      u = u_full[23:0];
    end
    cell_new = 8'((u - 24'h008000) >> 16);
    w_new    = {1'b0, cell_new, 16'h0} + 25'h0018000 - {1'b0, u};
  end

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (cmd_i == gtpi_pkg::CMD_LOAD) begin
            if (int'(field_select_i) < MaxFields) state_d = F_PUSH;
          end else if (is_tracer_i && cfg_i.rank != 2'd0 && total != 3'd0) begin
            state_d = F_MUL;
            ax_d    = 2'd0;
          end
        end
      end
      F_MUL:   state_d = F_CLAMP;
      F_CLAMP: begin
        if (ax_q == cfg_i.rank - 2'd1) begin
          state_d = F_BASE1;
        end else begin
          state_d = F_MUL;
          ax_d    = ax_q + 2'd1;
        end
      end
      F_BASE1: state_d = F_BASE2;
      F_BASE2: state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      batch_q  <= batch_end_i;
      for (int i = 0; i < 3; i++) begin
        cell_q[i] <= '0;
        w_q[i]    <= 17'h10000;
      end
      job_q              <= '0;
      job_q.is_load      <= (cmd_i == gtpi_pkg::CMD_LOAD);
      job_q.field_select <= field_select_i;
      job_q.cell_address <= cell_address_i;
      job_q.field_word   <= field_word_i;
    end
    if (state_q == F_MUL) begin
      prod_q <= 64'(diff[31:0]) * 64'(cfg_i.inv_cell_size);
      neg_q  <= diff[32];
      hi_q   <= 1'b0;
    end
    if (state_q == F_CLAMP) begin
      cell_q[ax_q] <= cell_new;
      w_q[ax_q]    <= w_new[16:0];
    end
    if (state_q == F_BASE1) begin
      t_q <= 12'(cell_q[2] * ny) + 12'(cell_q[1]);
    end
    if (state_q == F_BASE2) begin
      job_q.pos_x     <= pos_q[0];
      job_q.pos_y     <= pos_q[1];
      job_q.pos_z     <= pos_q[2];
      job_q.base      <= 12'(t_q * nx) + 12'(cell_q[0]);
      job_q.nx        <= 12'(nx);
      job_q.nxny      <= 12'(nx * ny);
      job_q.w0        <= w_q[0];
      job_q.w1        <= w_q[1];
      job_q.w2        <= w_q[2];
      job_q.rank      <= cfg_i.rank;
      job_q.fill_mode <= cfg_i.fill_mode;
      job_q.nf        <= nf;
      job_q.batch_end <= batch_q;
    end
  end

endmodule

`default_nettype wire

>>> src/gtpi_back.sv
// ----------------------------------------------------------------------------
// gtpi_back
// Executes queued jobs: store writes, position copies, corner reads and the
// nested linear steps, one step per cycle, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpi_back #(
  parameter int MaxFields = gtpi_pkg::MaxFieldsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire gtpi_pkg::job_t     job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      value_o,
  output logic                    kind_o,
  output logic [1:0]              slot_o,
  output logic                    last_of_particle_o,
  output logic                    batch_done_o
);

  localparam int Depth = MaxFields * gtpi_pkg::CellWords;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_POS  = 5'b00010,
    B_READ = 5'b00100,
    B_LERP = 5'b01000,
    B_OUT  = 5'b10000
  } back_state_e;

  // (a*w + b*(1-w)) in Q16, rounded to nearest with ties upward.
  function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [16:0]        w);
    logic signed [32:0] d;
    logic signed [50:0] t;
    d = 33'(a) - 33'(b);
    t = (51'(b) <<< 16) + 51'(d * $signed({1'b0, w})) + 51'sd32768;
    return t[47:16];
  endfunction

  back_state_e        state_q, state_d;
  gtpi_pkg::job_t     job_q;
  logic [1:0]         ax_q, f_q;
  logic [3:0]         k_q;
  logic [2:0]         s_q;
  logic               rd_pend_q;
  logic [2:0]         rd_k_q;
  logic signed [31:0] corner_q [8];
  logic signed [31:0] tmp_q [7];
  logic signed [31:0] res_q;

  logic               slot_free, emit;
  logic [3:0]         nc;
  logic [2:0]         s_last;
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]        ram_rdata;
  logic [11:0]        caddr;
  logic signed [31:0] la, lb, lr;
  logic [16:0]        lw;
  logic signed [31:0] pos_sel;

  logic signed [31:0] value_q;
  logic               out_valid_q, kind_q, last_q, batch_q;
  logic [1:0]         slot_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    unique case (job_q.rank)
      2'd1:    begin nc = 4'd2; s_last = 3'd0; end
      2'd2:    begin nc = 4'd4; s_last = 3'd2; end
      default: begin nc = 4'd8; s_last = 3'd6; end
    endcase
  end

  assign caddr = job_q.base + (k_q[0] ? 12'd1 : 12'd0) + (k_q[1] ? job_q.nx : 12'd0)
               + (k_q[2] ? job_q.nxny : 12'd0);

  assign ram_we    = pop_o && job_i.is_load;
  assign ram_waddr = AddrW'({job_i.field_select, job_i.cell_address});
  assign ram_re    = (state_q == B_READ) && (k_q != nc);
  assign ram_raddr = AddrW'({f_q, caddr});

  gtpi_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (job_i.field_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Step order: x rows, then their y pair, for the lower z plane and then the upper; z last.
  always_comb begin
    case (s_q)
      3'd0:    begin la = corner_q[0]; lb = corner_q[1]; lw = job_q.w0; end
      3'd1:    begin la = corner_q[2]; lb = corner_q[3]; lw = job_q.w0; end
      3'd2:    begin la = tmp_q[0];    lb = tmp_q[1];    lw = job_q.w1; end
      3'd3:    begin la = corner_q[4]; lb = corner_q[5]; lw = job_q.w0; end
      3'd4:    begin la = corner_q[6]; lb = corner_q[7]; lw = job_q.w0; end
      3'd5:    begin la = tmp_q[3];    lb = tmp_q[4];    lw = job_q.w1; end
      default: begin la = tmp_q[2];    lb = tmp_q[5];    lw = job_q.w2; end
    endcase
  end

  assign lr = lerp(la, lb, lw);

  always_comb begin
    case (ax_q)
      2'd1:    pos_sel = job_q.pos_y;
      2'd2:    pos_sel = job_q.pos_z;
      default: pos_sel = job_q.pos_x;
    endcase
  end

  assign emit = slot_free && ((state_q == B_POS) || (state_q == B_OUT));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o && !job_i.is_load) begin
          state_d = job_i.fill_mode ? B_POS : B_READ;
        end
      end
      B_POS: begin
        if (slot_free && ax_q == job_q.rank - 2'd1) begin
          state_d = (job_q.nf == 2'd0) ? B_IDLE : B_READ;
        end
      end
      B_READ:  if (k_q == nc) state_d = B_LERP;
      B_LERP:  if (s_q == s_last) state_d = B_OUT;
      B_OUT: begin
        if (slot_free) begin
          state_d = (f_q == job_q.nf - 2'd1) ? B_IDLE : B_READ;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      ax_q        <= '0;
      f_q         <= '0;
      k_q         <= '0;
      s_q         <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= ram_re;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          ax_q <= '0;
          f_q  <= '0;
          k_q  <= '0;
          s_q  <= '0;
        end
        B_POS:  if (slot_free) ax_q <= ax_q + 2'd1;
        B_READ: if (k_q != nc) k_q <= k_q + 4'd1;
        B_LERP: s_q <= s_q + 3'd1;
        B_OUT: begin
          if (slot_free) begin
            f_q <= f_q + 2'd1;
            k_q <= '0;
            s_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (ram_re) begin
      rd_k_q <= k_q[2:0];
    end
    if (rd_pend_q) begin
      corner_q[rd_k_q] <= ram_rdata;
    end
    if (state_q == B_LERP) begin
      tmp_q[s_q] <= lr;
      res_q      <= lr;
    end
    // Capture the batch flag with the item; the job may move on while it waits.
    if (emit) begin
      if (state_q == B_POS) begin
        value_q <= pos_sel;
        kind_q  <= 1'b0;
        slot_q  <= ax_q;
        last_q  <= (ax_q == job_q.rank - 2'd1) && (job_q.nf == 2'd0);
        batch_q <= (ax_q == job_q.rank - 2'd1) && (job_q.nf == 2'd0) && job_q.batch_end;
      end else begin
        value_q <= res_q;
        kind_q  <= 1'b1;
        slot_q  <= f_q;
        last_q  <= (f_q == job_q.nf - 2'd1);
        batch_q <= (f_q == job_q.nf - 2'd1) && job_q.batch_end;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign value_o            = value_q;
  assign kind_o             = kind_q;
  assign slot_o             = slot_q;
  assign last_of_particle_o = last_q;
  assign batch_done_o       = batch_q;

endmodule

`default_nettype wire
